// ===== rtl/per_channel_requant_add_s8_top_assert.svh =====
// Assertion macros for the per-channel requantizing add block.
// Used by the port-level checker; depends on nothing else.
`ifndef PER_CHANNEL_REQUANT_ADD_S8_TOP_ASSERT_SVH
`define PER_CHANNEL_REQUANT_ADD_S8_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcra checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcra checker: next-cycle property failed");

// Same-cycle implication that is checked during reset as well.
`define PCRA_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("pcra checker: reset-time property failed");

`endif

// ===== rtl/pcra_pkg.sv =====
// Shared constants, codes and types of the per-channel requantizing add block.
// No dependencies; used by scoped names in every file but the assertion header.
`timescale 1ns / 1ps

package pcra_pkg;

    // table depth and derived widths
    localparam int MAX_CHANNELS = 256;
    localparam int CHAN_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CFG_COUNT_W  = 9;
    localparam int CMP_W        = (CHAN_W + 1 > CFG_COUNT_W) ? CHAN_W + 1 : CFG_COUNT_W;
    localparam int LOAD_CH_W    = 8;

    // datapath widths
    localparam int VAL_W     = 8;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = VAL_W + MUL_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int FRAC_BITS = 24;
    localparam int SH_W      = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_BITS - 1));
    localparam int SAT_MAX = 127;
    localparam int SAT_MIN = -128;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [CFG_COUNT_W-1:0] CHANNEL_COUNT_RESET = CFG_COUNT_W'(1);

    // register index (word address bit)
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // operands of one data word after the table read
    typedef struct packed {
        logic [VAL_W-1:0] a_value;
        logic [VAL_W-1:0] b_value;
        logic [MUL_W-1:0] a_mul;
        logic [MUL_W-1:0] b_mul;
        logic             last;
    } pcra_operands_t;

endpackage

// ===== rtl/pcra_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on pcra_pkg for field widths.
`timescale 1ns / 1ps

interface pcra_elem_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [pcra_pkg::LOAD_CH_W-1:0]     load_channel;
    logic signed [pcra_pkg::MUL_W-1:0]  a_multiplier;
    logic signed [pcra_pkg::MUL_W-1:0]  b_multiplier;
    logic signed [pcra_pkg::VAL_W-1:0]  a_value;
    logic signed [pcra_pkg::VAL_W-1:0]  b_value;
    logic                               last_element;

    modport source (
        output valid, func, load_channel, a_multiplier, b_multiplier,
               a_value, b_value, last_element,
        input  ready
    );
    modport sink (
        input  valid, func, load_channel, a_multiplier, b_multiplier,
               a_value, b_value, last_element,
        output ready
    );
endinterface

interface pcra_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcra_pkg::VAL_W-1:0]  sum_value;
    logic                               last_out;

    modport source (output valid, sum_value, last_out, input ready);
    modport sink   (input valid, sum_value, last_out, output ready);
endinterface

// ===== rtl/pcra_requant.sv =====
// Multiply, round, shift and saturate stages of the requantizing add.
// Depends on pcra_pkg; fed by the table-read stage of the top level.
`timescale 1ns / 1ps

module pcra_requant (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  pcra_pkg::pcra_operands_t      op,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [pcra_pkg::VAL_W-1:0]    sum_value,
    output logic                          last_out
);

    // multiply stage registers
    logic                              mul_valid_reg;
    logic                              mul_valid_next;
    logic signed [pcra_pkg::PROD_W-1:0] prod_a_reg;
    logic signed [pcra_pkg::PROD_W-1:0] prod_b_reg;
    logic                              mul_last_reg;

    // stage enables: a stage moves when it is empty or its successor moves
    logic out_en;
    logic mul_en;

    assign out_en   = !res_valid || res_ready;
    assign mul_en   = !mul_valid_reg || out_en;
    assign op_ready = mul_en;

    // multiply stage
    logic signed [pcra_pkg::VAL_W-1:0]  a_val;
    logic signed [pcra_pkg::VAL_W-1:0]  b_val;
    logic signed [pcra_pkg::MUL_W-1:0]  a_mul;
    logic signed [pcra_pkg::MUL_W-1:0]  b_mul;
    logic signed [pcra_pkg::PROD_W-1:0] a_ext;
    logic signed [pcra_pkg::PROD_W-1:0] b_ext;
    logic signed [pcra_pkg::PROD_W-1:0] am_ext;
    logic signed [pcra_pkg::PROD_W-1:0] bm_ext;

    always_comb
    begin
        a_val  = op.a_value;
        b_val  = op.b_value;
        a_mul  = op.a_mul;
        b_mul  = op.b_mul;
        a_ext  = pcra_pkg::PROD_W'(a_val);
        b_ext  = pcra_pkg::PROD_W'(b_val);
        am_ext = pcra_pkg::PROD_W'(a_mul);
        bm_ext = pcra_pkg::PROD_W'(b_mul);
    end

    assign mul_valid_next = mul_en ? op_valid : mul_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en && op_valid)
        begin
            prod_a_reg   <= a_ext * am_ext;
            prod_b_reg   <= b_ext * bm_ext;
            mul_last_reg <= op.last;
        end
    end

    // add, round, floor shift by the fraction width, saturate to int8
    logic signed [pcra_pkg::ACC_W-1:0] pa_ext;
    logic signed [pcra_pkg::ACC_W-1:0] pb_ext;
    logic signed [pcra_pkg::ACC_W-1:0] acc;
    logic signed [pcra_pkg::SH_W-1:0]  shifted;
    logic [pcra_pkg::VAL_W-1:0]        sat;

    always_comb
    begin
        pa_ext  = pcra_pkg::ACC_W'(prod_a_reg);
        pb_ext  = pcra_pkg::ACC_W'(prod_b_reg);
        acc     = pa_ext + pb_ext + pcra_pkg::ROUND_BIAS;
        shifted = acc[pcra_pkg::ACC_W-1:pcra_pkg::FRAC_BITS];
        priority if (shifted > $signed(pcra_pkg::SH_W'(pcra_pkg::SAT_MAX)))
        begin
            sat = pcra_pkg::VAL_W'(pcra_pkg::SAT_MAX);
        end
        else if (shifted < $signed(pcra_pkg::SH_W'(pcra_pkg::SAT_MIN)))
        begin
            sat = pcra_pkg::VAL_W'(pcra_pkg::SAT_MIN);
        end
        else
        begin
            sat = shifted[pcra_pkg::VAL_W-1:0];
        end
    end

    // output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [pcra_pkg::VAL_W-1:0] sum_reg;
    logic                       last_reg;

    assign out_valid_next = out_en ? mul_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && mul_valid_reg)
        begin
            sum_reg  <= sat;
            last_reg <= mul_last_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign sum_value = sum_reg;
    assign last_out  = last_reg;

endmodule

// ===== rtl/per_channel_requant_add_s8_top.sv =====
// Top level of the per-channel requantizing int8 add.
// Depends on pcra_pkg, pcra_if and pcra_requant.
`timescale 1ns / 1ps

// Usage
//   elem (sink): one word per cycle unless stalled. func = load writes
//   a_multiplier and b_multiplier for load_channel into the scale table and
//   yields no result; func = data adds a_value and b_value, each scaled by
//   its Q24 multiplier for the running channel, and yields one result word
//   on result. The channel position advances per data word, wraps at
//   channel_count and restarts at zero after a word with last_element set.
//   APB port: register channel_count at byte address 0, pready always high.
// Timing
//   A data word goes through the table-read register, the multiply register
//   and the add/saturate output register. Sustained rate is one word per
//   cycle while result is taken; the single-port scale table takes one load
//   write or one data read per cycle, which matches one word accepted a cycle.
// Reset
//   Clears the pipeline valids, the channel position and sets channel_count
//   to 1. The scale table is not cleared; load every channel before use.
// Stall
//   When result is not taken, words keep entering until the three stages
//   fill; then elem.ready drops. Nothing is dropped or repeated.

module per_channel_requant_add_s8_top (
    input  logic                            clk,
    input  logic                            rst_n,
    pcra_elem_if.sink                       elem,
    pcra_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcra_pkg::PADDR_W-1:0]    paddr,
    input  logic [pcra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcra_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    // configuration register
    logic [pcra_pkg::CFG_COUNT_W-1:0] count_reg;
    logic [pcra_pkg::CFG_COUNT_W-1:0] count_next;
    logic                             reg_idx;
    logic                             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pcra_pkg::PADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == pcra_pkg::REG_CHANNEL_COUNT);
    assign count_next = cfg_wr ? pwdata[pcra_pkg::CFG_COUNT_W-1:0] : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= pcra_pkg::CHANNEL_COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata = (reg_idx == pcra_pkg::REG_CHANNEL_COUNT)
                    ? pcra_pkg::APB_DATA_W'(count_reg) : '0;

    // effective count: zero acts as one, above table depth acts as the depth
    logic [pcra_pkg::CMP_W-1:0] count_eff;

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            count_eff = pcra_pkg::CMP_W'(1);
        end
        else if (pcra_pkg::CMP_W'(count_reg) > pcra_pkg::CMP_W'(pcra_pkg::MAX_CHANNELS))
        begin
            count_eff = pcra_pkg::CMP_W'(pcra_pkg::MAX_CHANNELS);
        end
        else
        begin
            count_eff = pcra_pkg::CMP_W'(count_reg);
        end
    end

    // handshake into the table-read stage
    logic rd_valid_reg;
    logic rd_valid_next;
    logic rd_en;
    logic op_ready;
    logic accept;
    logic data_accept;
    logic load_wr;
    logic load_in_range;

    assign rd_en       = !rd_valid_reg || op_ready;
    assign elem.ready  = rd_en;
    assign accept      = elem.valid && rd_en;
    assign data_accept = accept && (elem.func == pcra_pkg::FUNC_DATA);
    assign load_in_range = pcra_pkg::CMP_W'(elem.load_channel)
                           < pcra_pkg::CMP_W'(pcra_pkg::MAX_CHANNELS);
    assign load_wr     = accept && (elem.func == pcra_pkg::FUNC_LOAD) && load_in_range;

    // channel position
    logic [pcra_pkg::CHAN_W-1:0] pos_reg;
    logic [pcra_pkg::CHAN_W-1:0] pos_next;
    logic [pcra_pkg::CHAN_W-1:0] pos_cur;
    logic [pcra_pkg::CMP_W-1:0]  pos_inc;

    always_comb
    begin
        pos_cur = (pcra_pkg::CMP_W'(pos_reg) >= count_eff) ? '0 : pos_reg;
        pos_inc = pcra_pkg::CMP_W'(pos_cur) + pcra_pkg::CMP_W'(1);
        pos_next = pos_reg;
        if (data_accept)
        begin
            if (elem.last_element || (pos_inc >= count_eff))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[pcra_pkg::CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // scale table: both multipliers of a channel in one word, one port
    logic [2*pcra_pkg::MUL_W-1:0] scale_mem [pcra_pkg::MAX_CHANNELS];
    logic [2*pcra_pkg::MUL_W-1:0] scale_rd_reg;
    logic [pcra_pkg::CHAN_W-1:0]  load_addr;

    assign load_addr = pcra_pkg::CHAN_W'(elem.load_channel);

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            scale_mem[load_addr] <= {elem.a_multiplier, elem.b_multiplier};
        end
        if (data_accept)
        begin
            scale_rd_reg <= scale_mem[pos_cur];
        end
    end

    // table-read stage: element values travel alongside the read
    logic [pcra_pkg::VAL_W-1:0] rd_a_reg;
    logic [pcra_pkg::VAL_W-1:0] rd_b_reg;
    logic                       rd_last_reg;

    assign rd_valid_next = rd_en ? data_accept : rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_accept)
        begin
            rd_a_reg    <= elem.a_value;
            rd_b_reg    <= elem.b_value;
            rd_last_reg <= elem.last_element;
        end
    end

    pcra_pkg::pcra_operands_t op;

    always_comb
    begin
        op.a_value = rd_a_reg;
        op.b_value = rd_b_reg;
        op.a_mul   = scale_rd_reg[2*pcra_pkg::MUL_W-1:pcra_pkg::MUL_W];
        op.b_mul   = scale_rd_reg[pcra_pkg::MUL_W-1:0];
        op.last    = rd_last_reg;
    end

    // multiply / requantize stages and output register
    pcra_requant u_requant (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (rd_valid_reg),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .sum_value (result.sum_value),
        .last_out  (result.last_out)
    );

endmodule

// ===== rtl/pcra_checker.sv =====
// Port-level checker for the per-channel requantizing add, with its bind.
// Depends on pcra_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "per_channel_requant_add_s8_top_assert.svh"

module pcra_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [pcra_pkg::VAL_W-1:0]      sum_value,
    input logic                            last_out,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [pcra_pkg::PADDR_W-1:0]    paddr,
    input logic [pcra_pkg::APB_DATA_W-1:0] pwdata,
    input logic [pcra_pkg::APB_DATA_W-1:0] prdata
);

    // helper terms
    logic                             out_stall;
    logic                             cfg_sel;
    logic                             cfg_hit;
    logic [pcra_pkg::CFG_COUNT_W-1:0] cfg_rd;
    logic [pcra_pkg::CFG_COUNT_W-1:0] cfg_wd;

    assign out_stall = out_valid && !out_ready;
    assign cfg_sel   = (paddr[pcra_pkg::PADDR_W-1] == pcra_pkg::REG_CHANNEL_COUNT);
    assign cfg_hit   = psel && penable && pwrite && cfg_sel;
    assign cfg_rd    = prdata[pcra_pkg::CFG_COUNT_W-1:0];
    assign cfg_wd    = pwdata[pcra_pkg::CFG_COUNT_W-1:0];

    // a stalled result word stays offered
    `PCRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)

    // and its payload does not change
    `PCRA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(sum_value) && $stable(last_out))

    // with the output register empty the pipeline drains, so input is taken
    `PCRA_ASSERT_ALWAYS(a_ready_when_empty, clk, !out_valid, in_ready)

    // reset leaves no result word behind
    `PCRA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

    // a channel_count write reads back on the next cycle
    `PCRA_ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_hit, !cfg_sel || (cfg_rd == $past(cfg_wd)))

endmodule

bind per_channel_requant_add_s8_top pcra_checker u_pcra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (elem.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sum_value (result.sum_value),
    .last_out  (result.last_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

// ===== tb/per_channel_requant_add_s8_top_test.sv =====
// Self-checking test of the per-channel requantizing int8 add top level.
// Depends on pcra_pkg, pcra_if and the per_channel_requant_add_s8_top RTL.
// Random stalls on both channels; channel_count is reprogrammed over APB.
`timescale 1ns / 1ps

module per_channel_requant_add_s8_top_test;

    localparam int CLK_PERIOD = 20;
    localparam int SETTLE_CYCLES = 10;
    localparam int WORDS_PER_PHASE = 70;
    localparam logic [pcra_pkg::PADDR_W-1:0] CHANNEL_COUNT_ADDR =
        pcra_pkg::PADDR_W'({pcra_pkg::REG_CHANNEL_COUNT, 2'b00});

    // one input word as presented on the element channel
    typedef struct {
        logic                              func;
        logic [pcra_pkg::LOAD_CH_W-1:0]    load_channel;
        logic signed [pcra_pkg::MUL_W-1:0] a_mul;
        logic signed [pcra_pkg::MUL_W-1:0] b_mul;
        logic signed [pcra_pkg::VAL_W-1:0] a_val;
        logic signed [pcra_pkg::VAL_W-1:0] b_val;
        logic                              last;
    } elem_word_t;

    // one result word
    typedef struct {
        logic signed [pcra_pkg::VAL_W-1:0] sum;
        logic                              last;
    } sum_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pcra_pkg::PADDR_W-1:0]    paddr;
    logic [pcra_pkg::APB_DATA_W-1:0] pwdata;
    logic [pcra_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    pcra_elem_if   elem_ch ();
    pcra_result_if result_ch ();

    per_channel_requant_add_s8_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .elem    (elem_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow state of the block
    logic signed [pcra_pkg::MUL_W-1:0] scale_a [pcra_pkg::MAX_CHANNELS];
    logic signed [pcra_pkg::MUL_W-1:0] scale_b [pcra_pkg::MAX_CHANNELS];
    int                                chan_pos;
    logic [pcra_pkg::CFG_COUNT_W-1:0]  cfg_count;

    // stimulus bookkeeping
    elem_word_t  elem_backlog [$];
    sum_word_t   pending_sums [$];
    int unsigned words_queued;
    int unsigned words_taken;
    int unsigned fail_count;
    bit          loaded [pcra_pkg::MAX_CHANNELS];

    // driver / monitor pacing
    elem_word_t tx_word;
    int         tx_wait;
    bit         tx_calm;
    int         rx_wait;
    bit         rx_calm;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[per_channel_requant_add_s8_top] ERROR");
        $finish;
    end

    function automatic int eff_channels(logic [pcra_pkg::CFG_COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > pcra_pkg::MAX_CHANNELS)
            return pcra_pkg::MAX_CHANNELS;
        return int'(v);
    endfunction

    // round half up in Q24, then saturate to int8
    function automatic logic signed [pcra_pkg::VAL_W-1:0] requant_sum(
        logic signed [pcra_pkg::VAL_W-1:0] a, logic signed [pcra_pkg::VAL_W-1:0] b,
        logic signed [pcra_pkg::MUL_W-1:0] am, logic signed [pcra_pkg::MUL_W-1:0] bm);
        longint acc;
        longint q;
        acc = longint'(a) * longint'(am) + longint'(b) * longint'(bm)
            + (longint'(1) <<< (pcra_pkg::FRAC_BITS - 1));
        q = acc >>> pcra_pkg::FRAC_BITS;
        if (q > pcra_pkg::SAT_MAX)
            q = pcra_pkg::SAT_MAX;
        else if (q < pcra_pkg::SAT_MIN)
            q = pcra_pkg::SAT_MIN;
        return q[pcra_pkg::VAL_W-1:0];
    endfunction

    // update shadow state for one accepted word, queue its result if any
    function automatic void apply_word(elem_word_t w);
        sum_word_t r;
        int        cnt;
        if (w.func == pcra_pkg::FUNC_LOAD)
        begin
            if (int'(w.load_channel) < pcra_pkg::MAX_CHANNELS)
            begin
                scale_a[w.load_channel] = w.a_mul;
                scale_b[w.load_channel] = w.b_mul;
            end
        end
        else
        begin
            cnt = eff_channels(cfg_count);
            if (chan_pos >= cnt)
                chan_pos = 0;
            r.sum  = requant_sum(w.a_val, w.b_val, scale_a[chan_pos], scale_b[chan_pos]);
            r.last = w.last;
            pending_sums.push_back(r);
            chan_pos = (w.last || chan_pos + 1 >= cnt) ? 0 : chan_pos + 1;
        end
    endfunction

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = ~calm;
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    // element driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            elem_ch.valid <= 1'b0;
            tx_wait = 0;
            tx_calm = 1'b0;
        end
        else
        begin
            if (elem_ch.valid && elem_ch.ready)
            begin
                apply_word(tx_word);
                words_taken++;
            end
            if (!(elem_ch.valid && !elem_ch.ready))
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    elem_ch.valid <= 1'b0;
                end
                else if (elem_backlog.size() > 0)
                begin
                    tx_word = elem_backlog.pop_front();
                    elem_ch.func         <= tx_word.func;
                    elem_ch.load_channel <= tx_word.load_channel;
                    elem_ch.a_multiplier <= tx_word.a_mul;
                    elem_ch.b_multiplier <= tx_word.b_mul;
                    elem_ch.a_value      <= tx_word.a_val;
                    elem_ch.b_value      <= tx_word.b_val;
                    elem_ch.last_element <= tx_word.last;
                    elem_ch.valid        <= 1'b1;
                    tx_wait = draw_gap(tx_calm);
                end
                else
                begin
                    elem_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        sum_word_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_wait = 0;
            rx_calm = 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $error("unexpected result word: sum_value %0d last_out %0b",
                           result_ch.sum_value, result_ch.last_out);
                    fail_count++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (result_ch.sum_value !== want.sum)
                    begin
                        $error("sum_value: expected %0d, actual %0d",
                               want.sum, result_ch.sum_value);
                        fail_count++;
                    end
                    if (result_ch.last_out !== want.last)
                    begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last, result_ch.last_out);
                        fail_count++;
                    end
                end
                rx_wait = draw_gap(rx_calm);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            result_ch.ready <= (rx_wait == 0);
        end
    end

    task automatic push_load(logic [pcra_pkg::LOAD_CH_W-1:0] ch,
                             logic signed [pcra_pkg::MUL_W-1:0] am,
                             logic signed [pcra_pkg::MUL_W-1:0] bm);
        elem_word_t w;
        w.func         = pcra_pkg::FUNC_LOAD;
        w.load_channel = ch;
        w.a_mul        = am;
        w.b_mul        = bm;
        w.a_val        = pcra_pkg::VAL_W'($urandom);
        w.b_val        = pcra_pkg::VAL_W'($urandom);
        w.last         = 1'($urandom);
        elem_backlog.push_back(w);
        loaded[ch] = 1'b1;
        words_queued++;
    endtask

    task automatic push_data(logic signed [pcra_pkg::VAL_W-1:0] a,
                             logic signed [pcra_pkg::VAL_W-1:0] b,
                             logic last);
        elem_word_t w;
        w.func         = pcra_pkg::FUNC_DATA;
        w.load_channel = pcra_pkg::LOAD_CH_W'($urandom);
        w.a_mul        = $urandom;
        w.b_mul        = $urandom;
        w.a_val        = a;
        w.b_val        = b;
        w.last         = last;
        elem_backlog.push_back(w);
        words_queued++;
    endtask

    // mostly moderate multipliers so that results do not all saturate
    function automatic logic signed [pcra_pkg::MUL_W-1:0] rand_mul();
        logic signed [pcra_pkg::MUL_W-1:0] m;
        case ($urandom_range(0, 7))
            0: m = $urandom;
            1: m = ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:
            begin
                m = $urandom_range(0, 1 << 24);
                if ($urandom_range(0, 1) == 1)
                    m = -m;
            end
        endcase
        return m;
    endfunction

    function automatic logic signed [pcra_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 8'sh7F;
            1: return -8'sh80;
            default: return pcra_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // all words taken, all results back, pipeline drained
    task automatic wait_idle();
        do
            @(posedge clk);
        while (words_taken != words_queued || pending_sums.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel_count(logic [pcra_pkg::APB_DATA_W-1:0] value);
        logic [pcra_pkg::APB_DATA_W-1:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CHANNEL_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_count = value[pcra_pkg::CFG_COUNT_W-1:0];
        // read back
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== pcra_pkg::APB_DATA_W'(cfg_count))
        begin
            $error("channel_count: expected %0d, actual %0d", cfg_count, rd);
            fail_count++;
        end
    endtask

    // reprogram, make sure every reachable channel holds multipliers, then stream
    task automatic run_phase(logic [pcra_pkg::APB_DATA_W-1:0] value);
        int          cnt;
        int          len;
        int unsigned start;
        bit          first;
        wait_idle();
        write_channel_count(value);
        cnt = eff_channels(value[pcra_pkg::CFG_COUNT_W-1:0]);
        for (int ch = 0; ch < cnt; ch++)
            if (!loaded[ch])
                push_load(pcra_pkg::LOAD_CH_W'(ch), rand_mul(), rand_mul());
        start = words_queued;
        first = 1'b1;
        while (words_queued - start < WORDS_PER_PHASE)
        begin
            case ($urandom_range(0, 9))
                0: push_load(pcra_pkg::LOAD_CH_W'($urandom), rand_mul(), rand_mul());
                1: push_load(pcra_pkg::LOAD_CH_W'($urandom_range(0, cnt - 1)),
                             rand_mul(), rand_mul());
                2:
                begin
                    // stray elements with no tensor end
                    repeat ($urandom_range(1, 4)) push_data(rand_val(), rand_val(), 1'b0);
                end
                default:
                begin
                    if (first)
                        len = cnt + $urandom_range(1, 3);
                    else if (2 * cnt + 1 < 24)
                        len = $urandom_range(1, 2 * cnt + 1);
                    else
                        len = $urandom_range(1, 24);
                    first = 1'b0;
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            push_load(pcra_pkg::LOAD_CH_W'($urandom_range(0, cnt - 1)),
                                      rand_mul(), rand_mul());
                        push_data(rand_val(), rand_val(), i == len - 1);
                    end
                end
            endcase
        end
        // leave the position mid-tensor for the next count change
        push_data(rand_val(), rand_val(), 1'b0);
    endtask

    initial
    begin
        logic [pcra_pkg::APB_DATA_W-1:0] counts [11];
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        elem_ch.valid        = 1'b0;
        elem_ch.func         = pcra_pkg::FUNC_LOAD;
        elem_ch.load_channel = '0;
        elem_ch.a_multiplier = '0;
        elem_ch.b_multiplier = '0;
        elem_ch.a_value      = '0;
        elem_ch.b_value      = '0;
        elem_ch.last_element = 1'b0;
        result_ch.ready      = 1'b0;
        chan_pos     = 0;
        cfg_count    = pcra_pkg::CHANNEL_COUNT_RESET;
        words_queued = 0;
        words_taken  = 0;
        fail_count   = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: three channels, saturation both ways, rounding ties,
        // loads between elements, tensor ends
        write_channel_count(32'd3);
        push_load(8'd0, 32'sh0100_0000, 32'sh0100_0000);
        push_load(8'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_load(8'd2, 32'sh0080_0000, 32'sh0000_0000);
        push_data(8'sh7F, 8'sh7F, 1'b0);
        push_data(-8'sh80, 8'sh7F, 1'b0);
        push_data(8'sh01, 8'sh00, 1'b0);
        push_data(-8'sh80, -8'sh80, 1'b0);
        push_load(8'd200, 32'shFFFF_FFFF, 32'sh0000_0001);
        push_data(8'sh7F, -8'sh80, 1'b0);
        push_data(-8'sh01, 8'sh00, 1'b0);
        push_data(8'sh00, 8'sh00, 1'b1);
        push_data(8'sh01, 8'sh01, 1'b0);
        push_data(8'sh7F, 8'sh7F, 1'b0);
        push_load(8'd2, -32'sh0100_0000, 32'sh8000_0000);
        push_data(8'sh05, 8'sh00, 1'b0);
        push_data(-8'sh80, 8'sh7F, 1'b1);
        push_load(8'd255, 32'sh8000_0000, 32'sh7FFF_FFFF);

        // count settings: extremes, zero, out of range, upper bits set
        counts = '{32'd4, 32'd256, 32'd0, 32'd1, 32'd511, 32'hFFFF_FE03,
                   32'd64, 32'd2, 32'd0, 32'd7, 32'd0};
        counts[8]  = $urandom_range(1, 256);
        counts[10] = $urandom_range(1, 32);
        foreach (counts[i])
            run_phase(counts[i]);

        wait_idle();
        if (fail_count == 0)
            $display("[per_channel_requant_add_s8_top] OK");
        else
            $display("[per_channel_requant_add_s8_top] ERROR");
        $finish;
    end

endmodule
